// ----- hdl/rff_pkg.sv -----
// Shared types and constants for the record field filter.
// Used by the channel interfaces, the parser, the evaluator and the top level.
package rff_pkg;

	// Record header mark
	localparam logic [7:0] MARK_FIRST  = 8'h7D;
	localparam logic [7:0] MARK_SECOND = 8'hCA;
	localparam logic [2:0] HDR_LEN     = 3'd4;

	// Field type codes
	localparam logic [7:0] TYPE_U8     = 8'h01;
	localparam logic [7:0] TYPE_U16    = 8'h02;
	localparam logic [7:0] TYPE_U32    = 8'h03;
	localparam logic [7:0] TYPE_I8     = 8'h04;
	localparam logic [7:0] TYPE_I16    = 8'h05;
	localparam logic [7:0] TYPE_I32    = 8'h06;
	localparam logic [7:0] TYPE_LOOKUP = 8'h12;

	// Comparison codes
	localparam logic [2:0] CMP_EQ = 3'd0;
	localparam logic [2:0] CMP_NE = 3'd1;
	localparam logic [2:0] CMP_GT = 3'd2;
	localparam logic [2:0] CMP_LT = 3'd3;
	localparam logic [2:0] CMP_GE = 3'd4;
	localparam logic [2:0] CMP_LE = 3'd5;

	// Configuration register indexes
	localparam logic [1:0] REG_FIELD_ORDINAL = 2'd0;
	localparam logic [1:0] REG_FIELD_TYPE    = 2'd1;
	localparam logic [1:0] REG_COMPARE_OP    = 2'd2;
	localparam logic [1:0] REG_COMPARE_VALUE = 2'd3;

	// Field parser state
	typedef enum logic [2:0] {
		PH_ORD = 3'b001,
		PH_LEN = 3'b010,
		PH_VAL = 3'b100
	} rff_phase_t;

	// Live configuration
	typedef struct packed {
		logic [4:0]         field_ordinal;
		logic [7:0]         field_type;
		logic [2:0]         compare_op;
		logic signed [32:0] compare_value;
	} rff_cfg_t;

	// End-of-record summary handed from parser to evaluator
	typedef struct packed {
		logic        header_ok;
		logic        field_found;
		logic [31:0] captured;
		logic [7:0]  target_length;
	} rff_snap_t;

endpackage

// ----- hdl/rff_channels.sv -----
// Valid/ready channel interfaces: record bytes in, results out, config writes.
// Depends on rff_pkg.
interface rff_in_if;
	import rff_pkg::*;
	logic       valid;
	logic       ready;
	logic [7:0] record_byte;
	logic       last_byte;
	modport source (output valid, output record_byte, output last_byte, input ready);
	modport sink   (input valid, input record_byte, input last_byte, output ready);
endinterface

interface rff_out_if;
	import rff_pkg::*;
	logic               valid;
	logic               ready;
	logic               header_ok;
	logic               field_found;
	logic signed [32:0] field_value;
	logic               passed;
	modport source (output valid, output header_ok, output field_found, output field_value,
		output passed, input ready);
	modport sink   (input valid, input header_ok, input field_found, input field_value,
		input passed, output ready);
endinterface

interface rff_cfg_if;
	import rff_pkg::*;
	logic        valid;
	logic        ready;
	logic [1:0]  index;
	logic [32:0] data;
	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- hdl/rff_parser.sv -----
// Byte-serial record parser: header check, field walk, target capture.
// Emits one summary word per record on its last byte. Depends on rff_pkg.
module rff_parser (
	input  logic              clk,
	input  logic              arst_n,
	rff_in_if.sink            rec,
	input  rff_pkg::rff_cfg_t cfg,
	output logic              snap_valid,
	output rff_pkg::rff_snap_t snap,
	input  logic              snap_ready
);
	import rff_pkg::*;

	// Per-record state
	logic [2:0]  header_count_q;
	logic        header_good_q;
	rff_phase_t  phase_q;
	logic [7:0]  bytes_left_q;
	logic        in_target_q;
	logic [7:0]  target_length_q;
	logic [31:0] captured_q;
	logic        target_complete_q;
	logic        search_closed_q;

	logic [2:0]  header_count_n;
	logic        header_good_n;
	rff_phase_t  phase_n;
	logic [7:0]  bytes_left_n;
	logic        in_target_n;
	logic [7:0]  target_length_n;
	logic [31:0] captured_n;
	logic        target_complete_n;
	logic        search_closed_n;

	logic        snap_valid_s1;
	rff_snap_t   snap_s1;
	logic        accept;
	logic [7:0]  b;
	logic [7:0]  idx;

	assign b          = rec.record_byte;
	assign rec.ready  = !snap_valid_s1 || snap_ready;
	assign accept     = rec.valid && rec.ready;
	assign snap_valid = snap_valid_s1;
	assign snap       = snap_s1;
	assign idx        = target_length_q - bytes_left_q;

	// Next state for one byte
	always_comb begin
		header_count_n    = header_count_q;
		header_good_n     = header_good_q;
		phase_n           = phase_q;
		bytes_left_n      = bytes_left_q;
		in_target_n       = in_target_q;
		target_length_n   = target_length_q;
		captured_n        = captured_q;
		target_complete_n = target_complete_q;
		search_closed_n   = search_closed_q;
		if (header_count_q < HDR_LEN) begin
			if (header_count_q == 3'd0 && b != MARK_FIRST) header_good_n = 1'b0;
			if (header_count_q == 3'd1 && b != MARK_SECOND) header_good_n = 1'b0;
			header_count_n = header_count_q + 3'd1;
		end else if (header_good_q && !search_closed_q) begin
			case (phase_q)
				PH_ORD: begin
					in_target_n = (b[4:0] == cfg.field_ordinal);
					phase_n     = PH_LEN;
				end
				PH_LEN: begin
					bytes_left_n = b;
					if (in_target_q) target_length_n = b;
					if (b == 8'd0) begin
						phase_n = PH_ORD;
						if (in_target_q) begin
							target_complete_n = 1'b1;
							search_closed_n   = 1'b1;
							in_target_n       = 1'b0;
						end
					end else begin
						phase_n = PH_VAL;
					end
				end
				PH_VAL: begin
					// first four value bytes land little-endian
					if (in_target_q && idx[7:2] == 6'd0) begin
						for (int k = 0; k < 4; k++) begin
							if (idx[1:0] == k[1:0]) captured_n[8*k +: 8] = captured_q[8*k +: 8] | b;
						end
					end
					bytes_left_n = bytes_left_q - 8'd1;
					if (bytes_left_n == 8'd0) begin
						phase_n = PH_ORD;
						if (in_target_q) begin
							target_complete_n = 1'b1;
							search_closed_n   = 1'b1;
							in_target_n       = 1'b0;
						end
					end
				end
				default: phase_n = PH_ORD;
			endcase
		end
	end

	// State update; cleared after each last byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			header_count_q    <= '0;
			header_good_q     <= 1'b1;
			phase_q           <= PH_ORD;
			bytes_left_q      <= '0;
			in_target_q       <= 1'b0;
			target_length_q   <= '0;
			captured_q        <= '0;
			target_complete_q <= 1'b0;
			search_closed_q   <= 1'b0;
		end else if (accept) begin
			if (rec.last_byte) begin
				header_count_q    <= '0;
				header_good_q     <= 1'b1;
				phase_q           <= PH_ORD;
				bytes_left_q      <= '0;
				in_target_q       <= 1'b0;
				target_length_q   <= '0;
				captured_q        <= '0;
				target_complete_q <= 1'b0;
				search_closed_q   <= 1'b0;
			end else begin
				header_count_q    <= header_count_n;
				header_good_q     <= header_good_n;
				phase_q           <= phase_n;
				bytes_left_q      <= bytes_left_n;
				in_target_q       <= in_target_n;
				target_length_q   <= target_length_n;
				captured_q        <= captured_n;
				target_complete_q <= target_complete_n;
				search_closed_q   <= search_closed_n;
			end
		end
	end

	// Summary register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			snap_valid_s1 <= 1'b0;
		end else if (accept && rec.last_byte) begin
			snap_valid_s1 <= 1'b1;
		end else if (snap_ready) begin
			snap_valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && rec.last_byte) begin
			snap_s1.header_ok     <= header_good_n && header_count_n[2];
			snap_s1.field_found   <= header_good_n && header_count_n[2] && target_complete_n;
			snap_s1.captured      <= captured_n;
			snap_s1.target_length <= target_length_n;
		end
	end

endmodule

// ----- hdl/rff_eval.sv -----
// Value decoder and comparator feeding the result register.
// Depends on rff_pkg and the output channel interface.
module rff_eval (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               snap_valid,
	input  rff_pkg::rff_snap_t snap,
	output logic               snap_ready,
	input  rff_pkg::rff_cfg_t  cfg,
	rff_out_if.source          res
);
	import rff_pkg::*;

	logic               valid_s2;
	logic               header_ok_s2;
	logic               field_found_s2;
	logic signed [32:0] field_value_s2;
	logic               passed_s2;

	logic               out_free;
	logic signed [32:0] value;
	logic               pass;
	logic [31:0]        c;
	logic [7:0]         n;

	assign c          = snap.captured;
	assign n          = snap.target_length;
	assign out_free   = !valid_s2 || res.ready;
	assign snap_ready = out_free;

	// Little-endian decode by type; short, absent or unknown gives zero
	always_comb begin
		value = '0;
		if (snap.field_found) begin
			case (cfg.field_type)
				TYPE_U8:  if (n != 8'd0) value = {25'd0, c[7:0]};
				TYPE_U16: if (n[7:1] != 7'd0) value = {17'd0, c[15:0]};
				TYPE_U32, TYPE_LOOKUP: if (n[7:2] != 6'd0) value = {1'b0, c};
				TYPE_I8:  if (n != 8'd0) value = {{25{c[7]}}, c[7:0]};
				TYPE_I16: if (n[7:1] != 7'd0) value = {{17{c[15]}}, c[15:0]};
				TYPE_I32: if (n[7:2] != 6'd0) value = {c[31], c};
				default:  value = '0;
			endcase
		end
	end

	// Exact signed compare
	always_comb begin
		case (cfg.compare_op)
			CMP_EQ:  pass = (value == cfg.compare_value);
			CMP_NE:  pass = (value != cfg.compare_value);
			CMP_GT:  pass = (value >  cfg.compare_value);
			CMP_LT:  pass = (value <  cfg.compare_value);
			CMP_GE:  pass = (value >= cfg.compare_value);
			CMP_LE:  pass = (value <= cfg.compare_value);
			default: pass = 1'b0;
		endcase
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (snap_valid && out_free) begin
			valid_s2 <= 1'b1;
		end else if (res.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (snap_valid && out_free) begin
			header_ok_s2   <= snap.header_ok;
			field_found_s2 <= snap.field_found;
			field_value_s2 <= value;
			passed_s2      <= pass;
		end
	end

	assign res.valid       = valid_s2;
	assign res.header_ok   = header_ok_s2;
	assign res.field_found = field_found_s2;
	assign res.field_value = field_value_s2;
	assign res.passed      = passed_s2;

endmodule

// ----- hdl/record_field_filter_unit.sv -----
// Record field filter: takes one record byte per cycle and on the last byte of a
// record produces one result word.
// The edge that accepts the last byte loads the summary register, and the result register
// takes the word from it once it is free; throughput is one byte per cycle, stalled only
// while both registers hold a word and res is not ready.
// Reset (arst_n low) clears the parser state, both handshake stages and sets the
// registers to ordinal 0, type u8, compare equal, compare value 0.
module record_field_filter_unit (
	input  logic      clk,
	input  logic      arst_n,
	rff_in_if.sink    rec,
	rff_out_if.source res,
	rff_cfg_if.sink   cfg
);
	import rff_pkg::*;

	rff_cfg_t  cfg_q;
	logic      snap_valid;
	rff_snap_t snap;
	logic      snap_ready;

	assign cfg.ready = 1'b1;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.field_ordinal <= '0;
			cfg_q.field_type    <= TYPE_U8;
			cfg_q.compare_op    <= CMP_EQ;
			cfg_q.compare_value <= '0;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_FIELD_ORDINAL: cfg_q.field_ordinal <= cfg.data[4:0];
				REG_FIELD_TYPE:    cfg_q.field_type    <= cfg.data[7:0];
				REG_COMPARE_OP:    cfg_q.compare_op    <= cfg.data[2:0];
				REG_COMPARE_VALUE: cfg_q.compare_value <= cfg.data;
				default: ;
			endcase
		end
	end

	rff_parser u_parser (
		.clk        (clk),
		.arst_n     (arst_n),
		.rec        (rec),
		.cfg        (cfg_q),
		.snap_valid (snap_valid),
		.snap       (snap),
		.snap_ready (snap_ready)
	);

	rff_eval u_eval (
		.clk        (clk),
		.arst_n     (arst_n),
		.snap_valid (snap_valid),
		.snap       (snap),
		.snap_ready (snap_ready),
		.cfg        (cfg_q),
		.res        (res)
	);

endmodule
